// ===== hdl/playfair_digraph_encryptor_defines.svh =====
// Assertion helpers used by the checker of this block.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_DEFINES_SVH

// Check on every clock edge outside reset.
`define PFENC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PFENC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pfenc_pkg.sv =====
package pfenc_pkg;

  localparam int SIDE   = 5;
  localparam int NCELLS = SIDE * SIDE;

  typedef logic [4:0] letter_t;
  typedef letter_t [NCELLS-1:0] cells_t;
  typedef logic [1:0] cfg_idx_t;

  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_I = 5'd8;

  localparam int KEY_A_W = 45;
  localparam int KEY_B_W = 40;
  localparam int KEY_C_W = 40;
  localparam int CFG_W   = KEY_A_W;

  localparam cfg_idx_t CFG_KEY_A = 2'd0;
  localparam cfg_idx_t CFG_KEY_B = 2'd1;
  localparam cfg_idx_t CFG_KEY_C = 2'd2;

  // Square for the keyword "monarchy".
  localparam logic [KEY_A_W-1:0] KEY_A_RST = 45'd1931746489804;
  localparam logic [KEY_B_W-1:0] KEY_B_RST = 40'd527551370371;
  localparam logic [KEY_C_W-1:0] KEY_C_RST = 40'd884450414160;

  typedef struct packed {
    letter_t first;
    letter_t second;
  } pair_t;

  typedef struct packed {
    letter_t p;
    letter_t q;
    logic    dup;
  } job_t;

endpackage

// ===== hdl/pfenc_cipher.sv =====
module pfenc_cipher
  import pfenc_pkg::*;
(
  input  cells_t  cells,
  input  letter_t p,
  input  letter_t q,
  output pair_t   pair
);

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  localparam logic [2:0] EDGE_POS = 3'(SIDE - 1);

  // First match in row-major order wins; no match lands on cell 0.
  function automatic pos_t locate(cells_t sq, letter_t l);
    pos_t res;
    res = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[r*SIDE+c] == l || (l == LETTER_J && sq[r*SIDE+c] == LETTER_I)) begin
          res.row = 3'(r);
          res.col = 3'(c);
        end
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == EDGE_POS) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic letter_t cell_of(cells_t sq, pos_t ps);
    logic [4:0] idx;
    idx = {ps.row, 2'b00} + {2'b00, ps.row} + {2'b00, ps.col};
    return sq[idx];
  endfunction

  pos_t a, b, e1, e2;

  always_comb begin
    a  = locate(cells, p);
    b  = locate(cells, q);
    e1 = a;
    e2 = b;
    if (a.row == b.row) begin
      e1.col = wrap_inc(a.col);
      e2.col = wrap_inc(b.col);
    end else if (a.col == b.col) begin
      e1.row = wrap_inc(a.row);
      e2.row = wrap_inc(b.row);
    end else begin
      e1.col = b.col;
      e2.col = a.col;
    end
    pair.first  = cell_of(cells, e1);
    pair.second = cell_of(cells, e2);
  end

endmodule

// ===== hdl/pfenc_outbuf.sv =====
module pfenc_outbuf
  import pfenc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  pair_t   pair,
  input  logic    dup,
  output logic    free,
  output logic    out_valid,
  input  logic    out_stall,
  output letter_t out_cipher_letter,
  output logic    out_last_of_run
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       dup_r;
  pair_t      pair_r;
  logic       take;

  assign out_valid         = valid_r;
  assign out_cipher_letter = idx_r[0] ? pair_r.second : pair_r.first;
  assign out_last_of_run   = dup_r ? (idx_r == 2'd3) : (idx_r == 2'd1);
  assign take              = valid_r && !out_stall;
  assign free              = !valid_r || (take && out_last_of_run);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (free) begin
      valid_nxt = load;
      idx_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload: refill on load only.
  always_ff @(posedge clk) begin
    if (free && load) begin
      pair_r <= pair;
      dup_r  <= dup;
    end
  end

endmodule

// ===== hdl/playfair_digraph_encryptor.sv =====
// Channel | Ports                                    | Beat moves when
// input   | in_valid in_stall in_plain_letter        | in_valid && !in_stall
//         | in_message_end                           |
// result  | out_valid out_stall out_cipher_letter    | out_valid && !out_stall
//         | out_last_of_run                          |
// config  | cfg_wr_en cfg_index cfg_wdata            | cfg_wr_en
//
// A beat that forms a digraph is registered in the digraph register and then
// loaded into the serializer, which shows its first cipher letter, then its
// second; a doubled final letter gives four. The output serializer, one cipher
// letter per cycle while out_stall is low, sets the sustained rate; input beats
// are taken every cycle while the digraph register has room.
// rst_n is synchronous: it empties the pipe, drops the pending letter and
// loads the "monarchy" square. A stalled result holds the pipe behind it.
module playfair_digraph_encryptor
  import pfenc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  letter_t          in_plain_letter,
  input  logic             in_message_end,
  output logic             out_valid,
  input  logic             out_stall,
  output letter_t          out_cipher_letter,
  output logic             out_last_of_run,
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [KEY_A_W-1:0] key_a_r;
  logic [KEY_B_W-1:0] key_b_r;
  logic [KEY_C_W-1:0] key_c_r;
  cells_t             cells;

  letter_t pend_letter_r, pend_letter_nxt;
  logic    pend_valid_r, pend_valid_nxt;
  job_t    job_r, job_nxt;
  logic    job_valid_r, job_valid_nxt;
  logic    job_make;
  logic    in_take;
  logic    buf_free;
  pair_t   pair;

  // Key square registers; cell 0 sits in the low bits of key A.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= KEY_A_RST;
      key_b_r <= KEY_B_RST;
      key_c_r <= KEY_C_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_A: key_a_r <= cfg_wdata;
        CFG_KEY_B: key_b_r <= cfg_wdata[KEY_B_W-1:0];
        CFG_KEY_C: key_c_r <= cfg_wdata[KEY_C_W-1:0];
        default:   ;
      endcase
    end
  end

  assign cells = {key_c_r, key_b_r, key_a_r};

  // Hold input while the digraph register waits on the serializer.
  assign in_stall = job_valid_r && !buf_free;
  assign in_take  = in_valid && !in_stall;

  // Digraph forming: pair with the pending letter, or with x on a double
  // or at the end of the message.
  always_comb begin
    pend_letter_nxt = pend_letter_r;
    pend_valid_nxt  = pend_valid_r;
    job_make        = 1'b0;
    job_nxt.p       = pend_letter_r;
    job_nxt.q       = LETTER_X;
    job_nxt.dup     = 1'b0;
    if (in_take) begin
      if (!pend_valid_r) begin
        if (in_message_end) begin
          job_make  = 1'b1;
          job_nxt.p = in_plain_letter;
        end else begin
          pend_letter_nxt = in_plain_letter;
          pend_valid_nxt  = 1'b1;
        end
      end else if (in_plain_letter != pend_letter_r) begin
        job_make       = 1'b1;
        job_nxt.q      = in_plain_letter;
        pend_valid_nxt = 1'b0;
      end else begin
        // Doubled letter: the same letter stays pending, or gets padded
        // again when it ends the message, giving the same digraph twice.
        job_make    = 1'b1;
        job_nxt.dup = in_message_end;
      end
      if (in_message_end) begin
        pend_valid_nxt  = 1'b0;
        pend_letter_nxt = '0;
      end
    end
  end

  // Advance the digraph register when the serializer takes it.
  always_comb begin
    job_valid_nxt = job_valid_r;
    if (buf_free) begin
      job_valid_nxt = 1'b0;
    end
    if (job_make) begin
      job_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      job_valid_r   <= 1'b0;
    end else begin
      pend_valid_r  <= pend_valid_nxt;
      pend_letter_r <= pend_letter_nxt;
      job_valid_r   <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_make) begin
      job_r <= job_nxt;
    end
  end

  pfenc_cipher u_cipher (
    .cells (cells),
    .p     (job_r.p),
    .q     (job_r.q),
    .pair  (pair)
  );

  pfenc_outbuf u_outbuf (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (job_valid_r),
    .pair              (pair),
    .dup               (job_r.dup),
    .free              (buf_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

// ===== hdl/pfenc_checker.sv =====
`include "playfair_digraph_encryptor_defines.svh"

module pfenc_checker
  import pfenc_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input letter_t out_cipher_letter,
  input logic    out_last_of_run
);

  `PFENC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `PFENC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_cipher_letter) && $stable(out_last_of_run), "stalled result beat changed")
  `PFENC_ASSERT(a_run_cont, out_valid && !out_stall && !out_last_of_run |=> out_valid, "run broke before its last beat")
  `PFENC_ASSERT(a_stall_cause, in_stall |-> out_valid, "input stalled with no result pending")

endmodule

bind playfair_digraph_encryptor pfenc_checker u_pfenc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cipher_letter (out_cipher_letter),
  .out_last_of_run   (out_last_of_run)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pfenc_pkg::*;

  // Run limits. The slowest correct run is far below the cycle limit: about
  // 430 letters, at most four cipher beats each, short random stalls and one
  // long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned HOLDOFF_CYCLES = 240;
  // A digraph passes the digraph register and the serializer before its letters
  // show up; leave a comfortable margin beyond that when draining.
  localparam int unsigned DRAIN_CYCLES   = 12;

  typedef struct packed {
    letter_t letter;
    logic    last;
  } cipher_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  letter_t          in_plain_letter = '0;
  logic             in_message_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  letter_t          out_cipher_letter;
  logic             out_last_of_run;
  logic             cfg_wr_en = 1'b0;
  cfg_idx_t         cfg_index = CFG_KEY_A;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Local copy of the key square registers and the digraph state.
  logic [KEY_A_W-1:0] square_a = KEY_A_RST;
  logic [KEY_B_W-1:0] square_b = KEY_B_RST;
  logic [KEY_C_W-1:0] square_c = KEY_C_RST;
  letter_t            held_letter = '0;
  logic               held_valid = 1'b0;

  // Cipher beats still owed by the block, oldest first.
  cipher_beat_t cipher_due[$];
  // Beats produced by the letter being enciphered right now.
  cipher_beat_t run_beats[$];

  int          mismatches = 0;
  int unsigned cycle_count = 0;
  logic        quiet_mode = 1'b0;
  int unsigned holdoff_reqs = 0;
  int unsigned holdoff_done = 0;
  int unsigned holdoff_left = 0;

  playfair_digraph_encryptor uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_plain_letter   (in_plain_letter),
    .in_message_end    (in_message_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter),
    .out_last_of_run   (out_last_of_run),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung block or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Playfair predictor
  // ---------------------------------------------------------------------------

  // Fetch one cell of the square, row-major, cell 0 in the low bits of key A.
  function automatic letter_t square_cell(int idx);
    if (idx < 9)
      return square_a[5*idx +: 5];
    else if (idx < 17)
      return square_b[5*(idx-9) +: 5];
    return square_c[5*(idx-17) +: 5];
  endfunction

  // First matching cell wins; j also matches a cell holding i. A letter found
  // nowhere sits in cell 0.
  function automatic int find_cell(letter_t letter);
    letter_t c;
    for (int k = 0; k < NCELLS; k++) begin
      c = square_cell(k);
      if (c == letter || (letter == LETTER_J && c == LETTER_I))
        return k;
    end
    return 0;
  endfunction

  function automatic void encipher_pair(letter_t p, letter_t q);
    int a, b, r1, c1, r2, c2, e1, e2;
    cipher_beat_t beat;
    a = find_cell(p);
    b = find_cell(q);
    r1 = a / SIDE;
    c1 = a % SIDE;
    r2 = b / SIDE;
    c2 = b % SIDE;
    if (r1 == r2) begin
      // same row: shift right, wrapping
      e1 = r1 * SIDE + (c1 + 1) % SIDE;
      e2 = r2 * SIDE + (c2 + 1) % SIDE;
    end else if (c1 == c2) begin
      // same column: shift down, wrapping
      e1 = ((r1 + 1) % SIDE) * SIDE + c1;
      e2 = ((r2 + 1) % SIDE) * SIDE + c2;
    end else begin
      // rectangle: swap columns
      e1 = r1 * SIDE + c2;
      e2 = r2 * SIDE + c1;
    end
    beat.last = 1'b0;
    beat.letter = square_cell(e1);
    run_beats.push_back(beat);
    beat.letter = square_cell(e2);
    run_beats.push_back(beat);
  endfunction

  // Advance the digraph state by one accepted letter and queue its beats.
  function automatic void encipher_letter(letter_t letter, logic msg_end);
    run_beats.delete();
    if (!held_valid) begin
      if (msg_end) begin
        encipher_pair(letter, LETTER_X);
      end else begin
        held_letter = letter;
        held_valid = 1'b1;
      end
    end else if (letter != held_letter) begin
      encipher_pair(held_letter, letter);
      held_valid = 1'b0;
    end else begin
      // doubled letter: pad the held one with x, keep the new one
      encipher_pair(held_letter, LETTER_X);
      if (msg_end)
        encipher_pair(letter, LETTER_X);
    end
    if (msg_end) begin
      held_valid = 1'b0;
      held_letter = '0;
    end
    if (run_beats.size() != 0)
      run_beats[run_beats.size()-1].last = 1'b1;
    foreach (run_beats[i])
      cipher_due.push_back(run_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall generation and beat checking
  // ---------------------------------------------------------------------------

  // Stall at random, about 17 percent of the time; hold off for a long stretch whenever
  // the stimulus asks; never stall in quiet mode.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_reqs != holdoff_done) begin
      out_stall <= 1'b1;
      holdoff_done <= holdoff_done + 1;
      holdoff_left <= HOLDOFF_CYCLES;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 17);
    end
  end

  // Compare every accepted cipher beat with the oldest one owed.
  always @(posedge clk) begin
    cipher_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_due.size() == 0) begin
        $error("unexpected beat: cipher_letter %0d last_of_run %0b",
               out_cipher_letter, out_last_of_run);
        mismatches++;
      end else begin
        want = cipher_due.pop_front();
        if (out_cipher_letter !== want.letter) begin
          $error("cipher_letter: expected %0d, actual %0d", want.letter, out_cipher_letter);
          mismatches++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic letter_t ch(byte c);
    return letter_t'(c - "a");
  endfunction

  // Offer one letter and hold it until the block takes it. Valid stays high
  // after the beat so back-to-back letters need no idle beat between them.
  task automatic send_letter(letter_t letter, logic msg_end);
    if (!quiet_mode && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_plain_letter <= letter;
    in_message_end <= msg_end;
    do @(posedge clk); while (in_stall);
    encipher_letter(letter, msg_end);
  endtask

  // Random message, flagged at its last letter. Bias toward doubled letters
  // and toward x, i and j, where the digraph rules get interesting.
  task automatic send_message(int unsigned len);
    letter_t prev, letter;
    int unsigned pick;
    prev = letter_t'($urandom_range(25));
    for (int unsigned n = 0; n < len; n++) begin
      pick = $urandom_range(99);
      if (pick < 20)
        letter = prev;
      else if (pick < 27)
        letter = LETTER_X;
      else if (pick < 31)
        letter = LETTER_I;
      else if (pick < 35)
        letter = LETTER_J;
      else
        letter = letter_t'($urandom_range(25));
      send_letter(letter, n == len - 1);
      prev = letter;
    end
  endtask

  // Drop valid, wait for every owed beat, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three key registers on consecutive edges; block must be idle.
  task automatic load_square(logic [KEY_A_W-1:0] a, logic [KEY_B_W-1:0] b,
                             logic [KEY_C_W-1:0] c);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_KEY_A;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_KEY_B;
    cfg_wdata <= CFG_W'(b);
    @(posedge clk);
    cfg_index <= CFG_KEY_C;
    cfg_wdata <= CFG_W'(c);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    square_a = a;
    square_b = b;
    square_c = c;
  endtask

  // Build either a proper square (shuffled alphabet minus one letter, usually
  // j) or raw random bits with repeats, missing letters and codes above z.
  task automatic load_random_square();
    int pool[26];
    int j, tmp;
    logic [KEY_A_W-1:0] a;
    logic [KEY_B_W-1:0] b;
    logic [KEY_C_W-1:0] c;
    if ($urandom_range(3) == 0) begin
      a = KEY_A_W'({$urandom, $urandom});
      b = KEY_B_W'({$urandom, $urandom});
      c = KEY_C_W'({$urandom, $urandom});
    end else begin
      for (int i = 0; i < 26; i++)
        pool[i] = i;
      for (int i = 25; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = pool[i];
        pool[i] = pool[j];
        pool[j] = tmp;
      end
      // most of the time leave j out, as the classic square does
      if ($urandom_range(3) != 0) begin
        for (int i = 0; i < 25; i++) begin
          if (pool[i] == LETTER_J) begin
            pool[i] = pool[25];
            pool[25] = LETTER_J;
          end
        end
      end
      for (int k = 0; k < 9; k++)
        a[5*k +: 5] = letter_t'(pool[k]);
      for (int k = 9; k < 17; k++)
        b[5*(k-9) +: 5] = letter_t'(pool[k]);
      for (int k = 17; k < 25; k++)
        c[5*(k-17) +: 5] = letter_t'(pool[k]);
    end
    load_square(a, b, c);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset square (keyword "monarchy"): each digraph rule and each padding case.
  task automatic test_reset_square();
    send_letter(ch("a"), 1'b0);   // rectangle, alphabet extremes
    send_letter(ch("z"), 1'b0);
    send_letter(ch("m"), 1'b0);   // same row, wraps right
    send_letter(ch("r"), 1'b0);
    send_letter(ch("r"), 1'b0);   // same column, wraps down
    send_letter(ch("z"), 1'b0);
    send_letter(ch("j"), 1'b0);   // j and i differ, but share the i cell
    send_letter(ch("i"), 1'b0);
    send_letter(ch("b"), 1'b0);   // doubled letter mid-message
    send_letter(ch("b"), 1'b0);
    send_letter(ch("c"), 1'b0);
    send_letter(ch("x"), 1'b0);   // doubled x ending a message: four beats
    send_letter(ch("x"), 1'b1);
    send_letter(ch("q"), 1'b1);   // lone letter padded with x
    send_letter(ch("e"), 1'b0);   // message ending on a full digraph
    send_letter(ch("f"), 1'b1);
    send_letter(ch("x"), 1'b1);   // lone x padded with x
  endtask

  // Extreme register values: an all-zero square (every cell matches a) and an
  // all-ones square (no letter found, cells above z come out as they are).
  task automatic test_key_extremes();
    wait_idle();
    load_square('0, '0, '0);
    send_letter(ch("a"), 1'b0);
    send_letter(ch("z"), 1'b1);
    wait_idle();
    load_square('1, '1, '1);
    send_letter(ch("d"), 1'b0);
    send_letter(ch("d"), 1'b1);
  endtask

  // Random squares with random messages; one phase runs with no idling.
  task automatic test_random_squares();
    int unsigned sent, len;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      load_random_square();
      quiet_mode <= (phase == 3);
      sent = 0;
      while (sent < 40) begin
        len = $urandom_range(9, 1);
        send_message(len);
        sent += len;
      end
    end
    quiet_mode <= 1'b0;
  endtask

  // Long receiver hold-off while letters keep coming: the block must fill
  // up, stall its input and lose nothing.
  task automatic test_backpressure();
    int unsigned sent, len;
    wait_idle();
    load_square(KEY_A_RST, KEY_B_RST, KEY_C_RST);
    holdoff_reqs <= holdoff_reqs + 1;
    sent = 0;
    while (sent < 40) begin
      len = $urandom_range(7, 1);
      send_message(len);
      sent += len;
    end
  endtask

  // Sender goes quiet until everything owed has come out, then resumes.
  task automatic test_drain_pause();
    for (int n = 0; n < 6; n++) begin
      send_message($urandom_range(8, 2));
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_square();
    test_key_extremes();
    test_random_squares();
    test_backpressure();
    test_drain_pause();

    wait_idle();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== playfair_digraph_encryptor.f =====
+incdir+hdl
hdl/pfenc_pkg.sv
hdl/pfenc_cipher.sv
hdl/pfenc_outbuf.sv
hdl/playfair_digraph_encryptor.sv
hdl/pfenc_checker.sv
verif/tb_top.sv
